### design/mdio_mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Shared codes, field widths and frame positions for the management master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

   // command codes carried in the request tuser
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // configuration register indexes
   localparam logic CSR_PHY_ADDRESS   = 1'b0;
   localparam logic CSR_PREAMBLE_BITS = 1'b1;

   // field widths
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned PRE_W   = 6;
   localparam int unsigned SLOT_W  = 7;
   localparam int unsigned REQ_W   = 24;
   localparam int unsigned RSP_W   = 24;

   // longest preamble, and frame positions counted after the preamble
   localparam logic [PRE_W-1:0]  PRE_MAX      = 6'd32;
   localparam logic [SLOT_W-1:0] POS_OP_HI    = 7'd2;
   localparam logic [SLOT_W-1:0] POS_OP_LO    = 7'd3;
   localparam logic [SLOT_W-1:0] POS_PHY_END  = 7'd8;
   localparam logic [SLOT_W-1:0] POS_REG_END  = 7'd13;
   localparam logic [SLOT_W-1:0] POS_TA_HI    = 7'd14;
   localparam logic [SLOT_W-1:0] POS_TA_LO    = 7'd15;
   localparam logic [SLOT_W-1:0] POS_DATA     = 7'd16;
   localparam logic [SLOT_W-1:0] POS_LAST_WR  = 7'd31;
   localparam logic [SLOT_W-1:0] POS_LAST_RD  = 7'd32;

   // request tdata layout, lowest bit first
   localparam int unsigned REQ_ADDR_LSB = 0;
   localparam int unsigned REQ_DATA_LSB = REQ_ADDR_LSB + ADDR_W;
   localparam int unsigned REQ_LINE_BIT = REQ_DATA_LSB + DATA_W;

   // response tdata layout, lowest bit first
   localparam int unsigned RSP_CLK_BIT   = 0;
   localparam int unsigned RSP_OUT_BIT   = 1;
   localparam int unsigned RSP_DRV_BIT   = 2;
   localparam int unsigned RSP_BUSY_BIT  = 3;
   localparam int unsigned RSP_DATA_LSB  = 4;

   // one slot's result
   typedef struct packed {
      logic              clock_pulse;
      logic              line_out;
      logic              line_drive;
      logic              busy_res;
      logic              frame_done;
      logic              read_valid;
      logic [DATA_W-1:0] read_data;
   } slot_result_type;

endpackage

### design/mdio_management_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_management_master
// Clause-22 management frame master stepped one bit slot per request beat.
// ----------------------------------------------------------------------------
// Usage: every request beat is one bit slot of the management interface. The
// tuser command starts a read or a write when no frame is running; otherwise
// the beat just advances the frame. Each request beat yields exactly one
// response beat giving the clock pulse, line level, drive enable and status
// of that slot; rsp_tlast marks the final slot of a frame and rsp_tuser
// flags a finished read, whose value is in the read data field.
// Timing: the response beat is registered and presented in the cycle after its request beat.
// Throughput: one beat per cycle while responses are taken; the slot decode is a
// counter compare and a shift between the request side and the response register.
// Stall: when rsp_tready is low with a response held, req_tready drops and
// the frame state does not advance until the held beat is taken.
// Configuration: csr writes are always taken; write them only while idle.
// Register 0 is the PHY address, register 1 the preamble length (capped
// at 32 ones).
// Reset: synchronous active-high; no frame running, PHY address 0, preamble
// 32, response register empty.
// ----------------------------------------------------------------------------
module mdio_management_master
   import mdio_mm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // reg_addr[4:0], write_data[20:5], line_in[21], pad
   input  logic [1:0]       req_tuser,   // cmd[1:0]
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // clock_pulse[0], line_out[1], line_drive[2],
                                         // busy_res[3], read_data[19:4], pad
   output logic             rsp_tuser,   // read_valid
   output logic             rsp_tlast,   // frame_done
   // configuration write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [PRE_W-1:0] csr_data
);

   // configuration registers
   logic [ADDR_W-1:0] phy_address_ff;
   logic [PRE_W-1:0]  preamble_bits_ff;

   // frame state
   logic              frame_active_ff, frame_active_in;
   logic              is_write_ff, is_write_in;
   logic [SLOT_W-1:0] slot_count_ff, slot_count_in;
   logic [ADDR_W-1:0] addr_latch_ff, addr_latch_in;
   logic [DATA_W-1:0] data_shift_ff, data_shift_in;

   // response register
   logic              rsp_valid_ff;
   slot_result_type   rsp_ff, rsp_in;

   // decode helpers
   logic [1:0]        cmd;
   logic [ADDR_W-1:0] reg_addr;
   logic [DATA_W-1:0] write_data;
   logic              line_in;
   logic              req_beat;
   logic              start;
   logic              active;
   logic              wr;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] shift;
   logic [SLOT_W-1:0] slot;
   logic [PRE_W-1:0]  pre_len;
   logic [SLOT_W-1:0] pos;
   logic [SLOT_W-1:0] last_pos;
   logic [SLOT_W-1:0] phy_sel;
   logic [SLOT_W-1:0] reg_sel;
   logic              done;

   assign cmd        = req_tuser;
   assign reg_addr   = req_tdata[REQ_ADDR_LSB +: ADDR_W];
   assign write_data = req_tdata[REQ_DATA_LSB +: DATA_W];
   assign line_in    = req_tdata[REQ_LINE_BIT];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // slot decode and next frame state
   always_comb begin
      start    = !frame_active_ff && ((cmd == CMD_READ) || (cmd == CMD_WRITE));
      active   = frame_active_ff || start;
      wr       = start ? (cmd == CMD_WRITE) : is_write_ff;
      addr     = start ? reg_addr : addr_latch_ff;
      shift    = start ? (wr ? write_data : '0) : data_shift_ff;
      slot     = start ? '0 : slot_count_ff;
      pre_len  = (preamble_bits_ff > PRE_MAX) ? PRE_MAX : preamble_bits_ff;
      last_pos = wr ? POS_LAST_WR : POS_LAST_RD;
      pos      = slot - {1'b0, pre_len};
      done     = 1'b0;

      rsp_in          = '0;
      data_shift_in   = shift;
      is_write_in     = wr;
      addr_latch_in   = addr;
      frame_active_in = active;
      slot_count_in   = slot;

      if (active && (slot >= {1'b0, pre_len}) && (pos >= last_pos)) begin
         pos  = last_pos;
         done = 1'b1;
      end
      phy_sel = POS_PHY_END - pos;
      reg_sel = POS_REG_END - pos;

      if (active) begin
         rsp_in.clock_pulse = 1'b1;
         rsp_in.line_drive  = 1'b1;
         if (slot < {1'b0, pre_len}) begin
            // preamble of ones
            rsp_in.line_out = 1'b1;
         end else if (pos == '0) begin
            rsp_in.line_out = 1'b0;
         end else if (pos == 7'd1) begin
            rsp_in.line_out = 1'b1;
         end else if (pos == POS_OP_HI) begin
            rsp_in.line_out = !wr;
         end else if (pos == POS_OP_LO) begin
            rsp_in.line_out = wr;
         end else if (pos <= POS_PHY_END) begin
            rsp_in.line_out = phy_address_ff[phy_sel[2:0]];
         end else if (pos <= POS_REG_END) begin
            rsp_in.line_out = addr[reg_sel[2:0]];
         end else if (wr) begin
            // turnaround 10 then data msb first
            if (pos == POS_TA_HI) begin
               rsp_in.line_out = 1'b1;
            end else if (pos == POS_TA_LO) begin
               rsp_in.line_out = 1'b0;
            end else begin
               rsp_in.line_out = shift[DATA_W-1];
               data_shift_in   = {shift[DATA_W-2:0], 1'b0};
            end
         end else begin
            // released turnaround, sampled data, trailer
            rsp_in.line_drive = 1'b0;
            if ((pos >= POS_DATA) && (pos <= POS_LAST_WR)) begin
               data_shift_in = {shift[DATA_W-2:0], line_in};
            end
            if (pos == POS_LAST_RD) begin
               rsp_in.read_valid = 1'b1;
               rsp_in.read_data  = shift;
            end
         end
         rsp_in.frame_done = done;
         if (done) begin
            frame_active_in = 1'b0;
            slot_count_in   = '0;
         end else begin
            slot_count_in = slot + 7'd1;
         end
      end
      rsp_in.busy_res = frame_active_in;
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phy_address_ff   <= '0;
         preamble_bits_ff <= PRE_MAX;
         frame_active_ff  <= 1'b0;
         is_write_ff      <= 1'b0;
         slot_count_ff    <= '0;
         addr_latch_ff    <= '0;
         data_shift_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PHY_ADDRESS:   phy_address_ff   <= csr_data[ADDR_W-1:0];
               CSR_PREAMBLE_BITS: preamble_bits_ff <= csr_data;
               default:           ;
            endcase
         end
         if (req_beat) begin
            frame_active_ff <= frame_active_in;
            is_write_ff     <= is_write_in;
            slot_count_ff   <= slot_count_in;
            addr_latch_ff   <= addr_latch_in;
            data_shift_ff   <= data_shift_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.read_valid;
   assign rsp_tlast  = rsp_ff.frame_done;
   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[RSP_CLK_BIT]                 = rsp_ff.clock_pulse;
      rsp_tdata[RSP_OUT_BIT]                 = rsp_ff.line_out;
      rsp_tdata[RSP_DRV_BIT]                 = rsp_ff.line_drive;
      rsp_tdata[RSP_BUSY_BIT]                = rsp_ff.busy_res;
      rsp_tdata[RSP_DATA_LSB +: DATA_W]      = rsp_ff.read_data;
   end

`ifndef SYNTHESIS
   // idle state keeps the slot counter cleared
   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> (slot_count_ff == '0))
      else $error("slot counter not cleared while idle");

   // the last slot of a frame leaves the block idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_done) |-> !rsp_ff.busy_res)
      else $error("frame done while still busy");

   // a read result only appears on a released final slot
   a_read_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |-> (rsp_ff.frame_done && !rsp_ff.line_drive))
      else $error("read result outside a released final slot");

   // the line level is zero whenever released
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.line_drive) |-> !rsp_ff.line_out)
      else $error("line level set while released");

   // a frame start is reflected in the busy state after the beat
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_beat && start && !done) |=> frame_active_ff)
      else $error("frame start did not set busy");
`endif

endmodule
